FILE: sv/bbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bilinear Bayer demosaic unit.
// No dependencies; every other file imports this package.
package bbd_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int QUEUE_DEPTH   = 8;
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [15:0] HEIGHT_RESET = 16'd480;

   // Configuration register indexes.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Input beat kinds.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic                   op;
      logic [SAMPLE_BITS-1:0] in_red;
      logic [SAMPLE_BITS-1:0] in_green;
      logic [SAMPLE_BITS-1:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] out_red;
      logic [SAMPLE_BITS-1:0] out_green;
      logic [SAMPLE_BITS-1:0] out_blue;
      logic                   frame_end;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] r;
      logic [SAMPLE_BITS-1:0] g;
      logic [SAMPLE_BITS-1:0] b;
   } pix_type;

   // One window column: index 0 is the upper row, 2 the lower row.
   typedef pix_type [2:0] pcol_type;

   // Each output channel is the truncated mean of four operands.
   typedef struct packed {
      logic [3:0][SAMPLE_BITS-1:0] r_ops;
      logic [3:0][SAMPLE_BITS-1:0] g_ops;
      logic [3:0][SAMPLE_BITS-1:0] b_ops;
      logic                        frame_end;
   } job_type;

   // Up to two jobs per cycle from the front end into the queue.
   typedef struct packed {
      logic [1:0] cnt;
      job_type    j0;
      job_type    j1;
   } push_type;

endpackage

FILE: sv/bbd_front.sv
`timescale 1ns / 1ps
// Front end: accepts beats, keeps counters, line stores and window, and
// turns each beat into zero, one or two averaging jobs. Uses bbd_pkg.
module bbd_front import bbd_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [11:0]          cfg_width,
   input  logic [15:0]          cfg_height,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   input  logic [QCNT_BITS-1:0] q_count,
   output push_type             push
);

   localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int WB  = ((CW > 12) ? CW : 12) + 1;
   localparam logic [WB-1:0] MAXW = WB'(MAX_WIDTH);

   localparam logic [1:0] COL_RED   = 2'd0;
   localparam logic [1:0] COL_GREEN = 2'd1;
   localparam logic [1:0] COL_BLUE  = 2'd2;

   function automatic logic [1:0] colour_of(pix_type p);
      logic [1:0] c;
      begin
         if (p.r >= p.g && p.r >= p.b) c = COL_RED;
         else if (p.g >= p.b) c = COL_GREEN;
         else c = COL_BLUE;
         return c;
      end
   endfunction

   function automatic job_type make_job(pcol_type l, pcol_type m, pcol_type rt,
                                        logic kfl, logic fend);
      job_type j;
      pix_type c;
      logic    rg;
      begin
         c  = m[1];
         rg = colour_of(kfl ? l[1] : rt[1]) == COL_RED;
         j.frame_end = fend;
         case (colour_of(c))
            COL_RED: begin
               j.r_ops = {4{c.r}};
               j.g_ops = {m[0].g, l[1].g, rt[1].g, m[2].g};
               j.b_ops = {l[0].b, rt[0].b, l[2].b, rt[2].b};
            end
            COL_GREEN: begin
               j.g_ops = {4{c.g}};
               // A mean of two is the mean of the pair taken twice.
               if (rg) begin
                  j.r_ops = {l[1].r, rt[1].r, l[1].r, rt[1].r};
                  j.b_ops = {m[0].b, m[2].b, m[0].b, m[2].b};
               end else begin
                  j.r_ops = {m[0].r, m[2].r, m[0].r, m[2].r};
                  j.b_ops = {l[1].b, rt[1].b, l[1].b, rt[1].b};
               end
            end
            default: begin
               j.b_ops = {4{c.b}};
               j.g_ops = {m[0].g, l[1].g, rt[1].g, m[2].g};
               j.r_ops = {l[0].r, rt[0].r, l[2].r, rt[2].r};
            end
         endcase
         return j;
      end
   endfunction

   // Counters.
   logic [AW-1:0] col_cnt_ff, col_cnt_in;
   logic [AW-1:0] drn_cnt_ff, drn_cnt_in;
   logic [15:0]   row_cnt_ff, row_cnt_in;

   // Accept-stage registers.
   logic          a_valid_ff;
   logic          a_drain_ff, a_top_ff, a_produce_ff, a_ge1_ff, a_ge2_ff;
   logic          a_last_ff, a_kprev_ff;
   logic [AW-1:0] a_col_ff;
   pix_type       a_cur2_ff;

   // Line stores with registered reads and write-around for the upper line.
   pix_type       upper_mem [MAX_WIDTH];
   pix_type       middle_mem [MAX_WIDTH];
   pix_type       up_rd_ff, mid_rd_ff;
   logic          fwd_ff, fwd_in;
   pix_type       fwd_data_ff;

   // Window: two earlier columns.
   pcol_type      wa_ff, wb_ff;

   logic [WB-1:0] w_eff, col_next;
   logic [15:0]   h16;
   logic          drain, ignore, accept, take, last;
   logic [AW-1:0] col;
   pix_type       new_pix;
   logic [QCNT_BITS:0] need;
   pcol_type      cur, l1;
   logic          e1, e2;
   job_type       job1, job2;

   always_comb begin
      if (cfg_width == 12'd0) w_eff = WB'(1);
      else if (WB'(cfg_width) > MAXW) w_eff = MAXW;
      else w_eff = WB'(cfg_width);
      h16   = (cfg_height == 16'd0) ? 16'd1 : cfg_height;

      drain  = req_data.op == OP_DRAIN;
      ignore = drain ? (row_cnt_ff < h16) : (row_cnt_ff >= h16);
      need   = (QCNT_BITS+1)'(q_count) + (a_valid_ff ? (QCNT_BITS+1)'(2) : '0)
               + (QCNT_BITS+1)'(2);
      req_ready = need <= (QCNT_BITS+1)'(QUEUE_DEPTH);
      accept = req_valid && req_ready;
      take   = accept && !ignore;

      col      = drain ? drn_cnt_ff : col_cnt_ff;
      col_next = WB'(col) + WB'(1);
      last     = col_next >= w_eff;
      new_pix  = '{r: req_data.in_red, g: req_data.in_green, b: req_data.in_blue};

      col_cnt_in = col_cnt_ff;
      drn_cnt_in = drn_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (take) begin
         if (!drain) begin
            if (last) begin
               col_cnt_in = '0;
               row_cnt_in = row_cnt_ff + 16'd1;
            end else begin
               col_cnt_in = AW'(col_next);
            end
         end else if (last) begin
            drn_cnt_in = '0;
            row_cnt_in = '0;
            col_cnt_in = '0;
         end else begin
            drn_cnt_in = AW'(col_next);
         end
      end

      // The upper line is written in the cycle after its beat is taken; a read
      // of the same entry in that cycle takes the value being written.
      fwd_in = a_valid_ff && !a_drain_ff && (col == a_col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         drn_cnt_ff <= '0;
         row_cnt_ff <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         drn_cnt_ff <= drn_cnt_in;
         row_cnt_ff <= row_cnt_in;
         a_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_drain_ff   <= drain;
         a_top_ff     <= drain ? (h16 == 16'd1) : (row_cnt_ff == 16'd1);
         a_produce_ff <= drain || (row_cnt_ff >= 16'd1);
         a_ge1_ff     <= col >= AW'(1);
         a_ge2_ff     <= (MAX_WIDTH > 2) ? (WB'(col) >= WB'(2)) : 1'b0;
         a_last_ff    <= last;
         a_kprev_ff   <= WB'(col) >= w_eff;
         a_col_ff     <= col;
         a_cur2_ff    <= new_pix;
         fwd_ff       <= fwd_in;
         fwd_data_ff  <= mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_rd_ff <= middle_mem[col];
      end
      if (take && !drain) begin
         middle_mem[col] <= new_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff <= upper_mem[col];
      end
      if (a_valid_ff && !a_drain_ff) begin
         upper_mem[a_col_ff] <= mid_rd_ff;
      end
   end

   always_comb begin
      cur[1] = mid_rd_ff;
      cur[2] = a_drain_ff ? mid_rd_ff : a_cur2_ff;
      if (a_top_ff) cur[0] = mid_rd_ff;
      else if (fwd_ff) cur[0] = fwd_data_ff;
      else cur[0] = up_rd_ff;

      e1 = a_valid_ff && a_produce_ff && a_ge1_ff;
      e2 = a_valid_ff && a_produce_ff && a_last_ff;
      l1   = a_ge2_ff ? wa_ff : wb_ff;
      job1 = make_job(l1, wb_ff, cur, a_kprev_ff, 1'b0);
      job2 = make_job(a_ge1_ff ? wb_ff : cur, cur, cur, 1'b1, a_drain_ff);

      push.cnt = {1'b0, e1} + {1'b0, e2};
      push.j0  = e1 ? job1 : job2;
      push.j1  = job2;
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         wa_ff <= wb_ff;
         wb_ff <= cur;
      end
   end

endmodule

FILE: sv/bbd_queue.sv
`timescale 1ns / 1ps
// Job queue between front and back end: up to two writes, one read a cycle.
// Uses bbd_pkg.
module bbd_queue import bbd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  push_type             push,
   input  logic                 pop,
   output job_type              head,
   output logic [QCNT_BITS-1:0] count
);

   job_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wp_ff, rp_ff, wp1;
   logic [QCNT_BITS-1:0] cnt_ff;

   assign wp1   = wp_ff + QPTR_BITS'(1);
   assign head  = entry_ff[rp_ff];
   assign count = cnt_ff;

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) entry_ff[wp_ff] <= push.j0;
      if (push.cnt == 2'd2) entry_ff[wp1] <= push.j1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_ff + QPTR_BITS'(push.cnt);
         rp_ff  <= rp_ff + QPTR_BITS'(pop);
         cnt_ff <= cnt_ff + QCNT_BITS'(push.cnt) - QCNT_BITS'(pop);
      end
   end

endmodule

FILE: sv/bbd_back.sv
`timescale 1ns / 1ps
// Back end: averages the four operands of each channel and holds the
// result beat in the output register. Uses bbd_pkg.
module bbd_back import bbd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  job_type              head,
   input  logic [QCNT_BITS-1:0] count,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   logic    valid_ff;
   rsp_type data_ff, data_in;

   function automatic logic [SAMPLE_BITS-1:0] mean4(logic [3:0][SAMPLE_BITS-1:0] v);
      logic [SAMPLE_BITS+1:0] s;
      begin
         s = (SAMPLE_BITS+2)'(v[0]) + (SAMPLE_BITS+2)'(v[1])
           + (SAMPLE_BITS+2)'(v[2]) + (SAMPLE_BITS+2)'(v[3]);
         return s[SAMPLE_BITS+1:2];
      end
   endfunction

   always_comb begin
      pop = (count != '0) && (!valid_ff || rsp_ready);
      data_in.out_red   = mean4(head.r_ops);
      data_in.out_green = mean4(head.g_ops);
      data_in.out_blue  = mean4(head.b_ops);
      data_in.frame_end = head.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: sv/bilinear_bayer_demosaic_unit.sv
`timescale 1ns / 1ps
// Bilinear Bayer demosaic unit, top level. Uses bbd_pkg, bbd_front,
// bbd_queue and bbd_back.
// Throughput: one beat per cycle; the eight-entry job queue is the only
// limit, and it drains one result a cycle unless a held result is not taken.
// Path: a result goes from the beat that causes it through the line store
// read registers, the queue and the output register.
// Reset: synchronous; counters, queue and output clear, registers go to
// 640 by 480. The line stores hold no reset value and need no clear pass.
module bilinear_bayer_demosaic_unit import bbd_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers; the user must write them only while the unit is idle; the unit does not enforce this.
   logic [11:0] width_ff;
   logic [15:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= csr_wdata[11:0];
            REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The front end classifies each beat and emits averaging jobs; it holds
   // off input while the queue could not take two jobs for every beat in
   // flight, so its inner pipeline never has to stall.
   push_type             push;
   job_type              head;
   logic [QCNT_BITS-1:0] q_count;
   logic                 pop;

   bbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_count    (q_count),
      .push       (push)
   );

   bbd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   // The back end turns one job into one result beat and keeps it in the
   // output register until it is taken.
   bbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .count     (q_count),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
